@@ src/tape_machine_with_pixel_draw_defines.svh @@
// Assertion helpers shared by the tape machine RTL.
// Each one samples on clk and is off while arst_n is low.
`ifndef TAPE_MACHINE_WITH_PIXEL_DRAW_DEFINES_SVH
`define TAPE_MACHINE_WITH_PIXEL_DRAW_DEFINES_SVH

// Check that a property holds at every clock edge outside reset.
`define TMPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define TMPD_NEVER(lbl, cond, msg) \
	`TMPD_ASSERT(lbl, !(cond), msg)

`endif

@@ src/tmpd_pkg.sv @@
`default_nettype none

package tmpd_pkg;

	localparam int TAPE_CELLS  = 1024;
	localparam int TAPE_AW     = $clog2(TAPE_CELLS);
	localparam int CELL_W      = 32;
	localparam int IMAGE_SIDE  = 100;
	localparam int COORD_W     = $clog2(IMAGE_SIDE);
	localparam int COLOR_W     = 8;
	localparam int CHAR_W      = 8;
	localparam int LOOP_DEPTH  = 64;
	localparam int STK_AW      = $clog2(LOOP_DEPTH);
	localparam int DEPTH_W     = STK_AW + 1;
	localparam int PROG_W      = 12;
	localparam int OP_W        = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int DRAW_CNT_W  = 2;

	// Commands of the tape machine
	typedef enum logic [OP_W-1:0] {
		OP_INC   = 3'd0,
		OP_DEC   = 3'd1,
		OP_RIGHT = 3'd2,
		OP_LEFT  = 3'd3,
		OP_OPEN  = 3'd4,
		OP_CLOSE = 3'd5,
		OP_PRINT = 3'd6,
		OP_DRAW  = 3'd7
	} op_t;

	// Back end sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_EXEC,
		ST_MOVE,
		ST_CLOSE,
		ST_DRAW
	} st_t;

	// One decoded command as it sits in the queue
	typedef struct packed {
		op_t              op;
		logic [PROG_W-1:0] idx;
		logic [PROG_W-1:0] nxt;
	} item_t;

	// Queue head offered to the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	// Back end status returned to the front end
	typedef struct packed {
		logic pop;
		logic busy_clear;
	} back_stat_t;

endpackage

`default_nettype wire

@@ src/tape_machine_with_pixel_draw.sv @@
// Channel | Handshake            | Word
// --------+----------------------+---------------------------------------------
// in      | in_valid / in_ready   | operation, instr_index
// out     | out_valid / out_ready | next_index, char_valid, char_out, pixel_*,
//         |                       | red, green, blue, stack_error
//
// Inc, dec, loop open, print, a loop close on a zero cell or empty stack, a
// pointer move at a tape end and a draw that is skipped early finish in the
// execute state. Any other pointer move reloads the current cell from the tape
// store, a taken loop close reads the loop stack, and a draw inside the tape
// with x in the image makes four reads of the single-port tape store.
// After reset a clearing pass writes all 1024 tape cells with in_ready low. A
// two-word queue takes commands while the back end or the output register
// stalls.
`default_nettype none

module tape_machine_with_pixel_draw (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [tmpd_pkg::OP_W-1:0]     operation,
	input  wire logic [tmpd_pkg::PROG_W-1:0]   instr_index,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [tmpd_pkg::PROG_W-1:0]        next_index,
	output logic                              char_valid,
	output logic [tmpd_pkg::CHAR_W-1:0]        char_out,
	output logic                              pixel_valid,
	output logic [tmpd_pkg::COORD_W-1:0]       pixel_row,
	output logic [tmpd_pkg::COORD_W-1:0]       pixel_col,
	output logic [tmpd_pkg::COLOR_W-1:0]       red,
	output logic [tmpd_pkg::COLOR_W-1:0]       green,
	output logic [tmpd_pkg::COLOR_W-1:0]       blue,
	output logic                              stack_error
);
	import tmpd_pkg::*;

	head_t      head;
	back_stat_t stat;

	// Accept and queue commands
	tmpd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.instr_index (instr_index),
		.head        (head),
		.stat        (stat)
	);

	// Execute commands against tape and loop stack
	tmpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.next_index  (next_index),
		.char_valid  (char_valid),
		.char_out    (char_out),
		.pixel_valid (pixel_valid),
		.pixel_row   (pixel_row),
		.pixel_col   (pixel_col),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.stack_error (stack_error)
	);

endmodule

`default_nettype wire

@@ src/tmpd_front.sv @@
`default_nettype none

module tmpd_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [tmpd_pkg::OP_W-1:0]   operation,
	input  wire logic [tmpd_pkg::PROG_W-1:0] instr_index,
	output tmpd_pkg::head_t                 head,
	input  wire tmpd_pkg::back_stat_t        stat
);
	import tmpd_pkg::*;

	`include "tape_machine_with_pixel_draw_defines.svh"

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;
	item_t             word;

	// Accept while there is room and the tape is not being cleared
	assign in_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH)) && !stat.busy_clear;
	assign push     = in_valid && in_ready;
	assign pop      = stat.pop;

	// Classify the incoming word and precompute the fall-through index
	always_comb begin
		word.op  = op_t'(operation);
		word.idx = instr_index;
		word.nxt = instr_index + PROG_W'(1);
	end

	// Store the word
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= word;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.item  = slot_q[rd_ptr_q];

	`TMPD_ASSERT(a_cnt_bound, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue count over depth")
	`TMPD_ASSERT(a_pop_nonempty, pop |-> (cnt_q != '0), "pop from empty queue")
	`TMPD_ASSERT(a_push_grows, (push && !pop) |=> (cnt_q == $past(cnt_q) + QCNT_W'(1)),
		"queue count did not grow on push")

endmodule

`default_nettype wire

@@ src/tmpd_back.sv @@
`default_nettype none

module tmpd_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tmpd_pkg::head_t               head,
	output tmpd_pkg::back_stat_t              stat,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [tmpd_pkg::PROG_W-1:0]        next_index,
	output logic                              char_valid,
	output logic [tmpd_pkg::CHAR_W-1:0]        char_out,
	output logic                              pixel_valid,
	output logic [tmpd_pkg::COORD_W-1:0]       pixel_row,
	output logic [tmpd_pkg::COORD_W-1:0]       pixel_col,
	output logic [tmpd_pkg::COLOR_W-1:0]       red,
	output logic [tmpd_pkg::COLOR_W-1:0]       green,
	output logic [tmpd_pkg::COLOR_W-1:0]       blue,
	output logic                              stack_error
);
	import tmpd_pkg::*;

	`include "tape_machine_with_pixel_draw_defines.svh"

	localparam logic [TAPE_AW-1:0] TAPE_LAST = TAPE_AW'(TAPE_CELLS - 1);
	localparam logic [TAPE_AW-1:0] DRAW_LAST = TAPE_AW'(TAPE_CELLS - 5);

	// Tape and loop stack stores
	logic [CELL_W-1:0] tape_mem [TAPE_CELLS];
	logic [PROG_W-1:0] stk_mem  [LOOP_DEPTH];
	logic [CELL_W-1:0] tape_rd_q;
	logic [PROG_W-1:0] stk_rd_q;

	// Architectural state
	st_t                 state_q, state_nx;
	logic [TAPE_AW-1:0]  clr_q;
	logic [TAPE_AW-1:0]  dp_q;
	logic [CELL_W-1:0]   cur_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic [DRAW_CNT_W-1:0] cnt_q;
	logic [COORD_W-1:0]  y_q;
	logic                y_ok_q;
	logic [COLOR_W-1:0]  r_q;
	logic [COLOR_W-1:0]  g_q;

	// Output register
	logic                ovalid_q;
	logic [PROG_W-1:0]   o_next_q;
	logic                o_cv_q;
	logic [CHAR_W-1:0]   o_char_q;
	logic                o_pv_q;
	logic [COORD_W-1:0]  o_row_q;
	logic [COORD_W-1:0]  o_col_q;
	logic [COLOR_W-1:0]  o_r_q;
	logic [COLOR_W-1:0]  o_g_q;
	logic [COLOR_W-1:0]  o_b_q;
	logic                o_err_q;

	// Decoded conditions
	item_t              it;
	logic               out_free;
	logic               go;
	logic               x_ok;
	logic               draw_fits;
	logic [DEPTH_W-1:0] depth_dec;
	logic [TAPE_AW-1:0] dp_inc;
	logic [TAPE_AW-1:0] dp_dec;

	// Control from the action block
	logic                pop;
	logic                produce;
	logic                tw_en;
	logic [TAPE_AW-1:0]  tw_addr;
	logic [CELL_W-1:0]   tw_data;
	logic                tr_en;
	logic [TAPE_AW-1:0]  tr_addr;
	logic                sw_en;
	logic                sr_en;
	logic                cur_we;
	logic [CELL_W-1:0]   cur_nx;
	logic                dp_we;
	logic [TAPE_AW-1:0]  dp_nx;
	logic                depth_we;
	logic [DEPTH_W-1:0]  depth_nx;
	logic                draw_cap;
	logic [PROG_W-1:0]   res_next;
	logic                res_cv;
	logic [CHAR_W-1:0]   res_char;
	logic                res_pv;
	logic [COORD_W-1:0]  res_row;
	logic [COORD_W-1:0]  res_col;
	logic [COLOR_W-1:0]  res_r;
	logic [COLOR_W-1:0]  res_g;
	logic [COLOR_W-1:0]  res_b;
	logic                res_err;

	assign it        = head.item;
	assign out_free  = !ovalid_q || out_ready;
	assign go        = head.valid && out_free;
	assign x_ok      = cur_q < CELL_W'(IMAGE_SIDE);
	assign draw_fits = dp_q <= DRAW_LAST;
	assign depth_dec = depth_q - DEPTH_W'(1);
	assign dp_inc    = dp_q + TAPE_AW'(1);
	assign dp_dec    = dp_q - TAPE_AW'(1);

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == TAPE_LAST) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (go) begin
					unique case (it.op)
						OP_RIGHT: begin
							if (dp_q != TAPE_LAST) begin
								state_nx = ST_MOVE;
							end
						end
						OP_LEFT: begin
							if (dp_q != '0) begin
								state_nx = ST_MOVE;
							end
						end
						OP_CLOSE: begin
							if (depth_q != '0 && cur_q != '0) begin
								state_nx = ST_CLOSE;
							end
						end
						OP_DRAW: begin
							if (draw_fits && x_ok) begin
								state_nx = ST_DRAW;
							end
						end
						default: begin
							state_nx = ST_EXEC;
						end
					endcase
				end
			end
			ST_MOVE: begin
				state_nx = ST_EXEC;
			end
			ST_CLOSE: begin
				if (out_free) begin
					state_nx = ST_EXEC;
				end
			end
			ST_DRAW: begin
				if (cnt_q == '1 && out_free) begin
					state_nx = ST_EXEC;
				end
			end
			default: begin
				state_nx = ST_CLEAR;
			end
		endcase
	end

	// Actions of each state
	always_comb begin
		pop      = 1'b0;
		produce  = 1'b0;
		tw_en    = 1'b0;
		tw_addr  = dp_q;
		tw_data  = cur_q;
		tr_en    = 1'b0;
		tr_addr  = dp_inc;
		sw_en    = 1'b0;
		sr_en    = 1'b0;
		cur_we   = 1'b0;
		cur_nx   = cur_q;
		dp_we    = 1'b0;
		dp_nx    = dp_q;
		depth_we = 1'b0;
		depth_nx = depth_q;
		draw_cap = 1'b0;
		res_next = it.nxt;
		res_cv   = 1'b0;
		res_char = '0;
		res_pv   = 1'b0;
		res_row  = '0;
		res_col  = '0;
		res_r    = '0;
		res_g    = '0;
		res_b    = '0;
		res_err  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				tw_en   = 1'b1;
				tw_addr = clr_q;
				tw_data = '0;
			end
			ST_EXEC: begin
				if (go) begin
					unique case (it.op)
						OP_INC: begin
							cur_we  = 1'b1;
							cur_nx  = cur_q + CELL_W'(1);
							tw_en   = 1'b1;
							tw_data = cur_nx;
							pop     = 1'b1;
							produce = 1'b1;
						end
						OP_DEC: begin
							cur_we  = 1'b1;
							cur_nx  = cur_q - CELL_W'(1);
							tw_en   = 1'b1;
							tw_data = cur_nx;
							pop     = 1'b1;
							produce = 1'b1;
						end
						OP_RIGHT: begin
							pop     = 1'b1;
							produce = 1'b1;
							// Hold at the last cell; else reload the current cell
							if (dp_q != TAPE_LAST) begin
								dp_we   = 1'b1;
								dp_nx   = dp_inc;
								tr_en   = 1'b1;
								tr_addr = dp_inc;
							end
						end
						OP_LEFT: begin
							pop     = 1'b1;
							produce = 1'b1;
							if (dp_q != '0) begin
								dp_we   = 1'b1;
								dp_nx   = dp_dec;
								tr_en   = 1'b1;
								tr_addr = dp_dec;
							end
						end
						OP_OPEN: begin
							pop     = 1'b1;
							produce = 1'b1;
							if (depth_q < DEPTH_W'(LOOP_DEPTH)) begin
								sw_en    = 1'b1;
								depth_we = 1'b1;
								depth_nx = depth_q + DEPTH_W'(1);
							end else begin
								res_err = 1'b1;
							end
						end
						OP_CLOSE: begin
							// Empty stack flags; zero cell drops the entry; else fetch it
							if (depth_q == '0) begin
								pop     = 1'b1;
								produce = 1'b1;
								res_err = 1'b1;
							end else if (cur_q == '0) begin
								pop      = 1'b1;
								produce  = 1'b1;
								depth_we = 1'b1;
								depth_nx = depth_dec;
							end else begin
								sr_en = 1'b1;
							end
						end
						OP_PRINT: begin
							pop      = 1'b1;
							produce  = 1'b1;
							res_cv   = 1'b1;
							res_char = cur_q[CHAR_W-1:0];
						end
						OP_DRAW: begin
							// Skip at once when the tape end or x rules the pixel out
							if (draw_fits && x_ok) begin
								tr_en   = 1'b1;
								tr_addr = dp_inc;
							end else begin
								pop     = 1'b1;
								produce = 1'b1;
							end
						end
					endcase
				end
			end
			ST_MOVE: begin
				cur_we = 1'b1;
				cur_nx = tape_rd_q;
			end
			ST_CLOSE: begin
				if (out_free) begin
					pop      = 1'b1;
					produce  = 1'b1;
					res_next = stk_rd_q + PROG_W'(1);
				end
			end
			ST_DRAW: begin
				if (cnt_q != '1) begin
					draw_cap = 1'b1;
					tr_en    = 1'b1;
					tr_addr  = dp_q + TAPE_AW'(cnt_q) + TAPE_AW'(2);
				end else if (out_free) begin
					pop     = 1'b1;
					produce = 1'b1;
					if (y_ok_q) begin
						res_pv  = 1'b1;
						res_row = cur_q[COORD_W-1:0];
						res_col = y_q;
						res_r   = r_q;
						res_g   = g_q;
						res_b   = tape_rd_q[COLOR_W-1:0];
					end
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// Single-port tape store: one write or one read per cycle
	always_ff @(posedge clk) begin
		if (tw_en) begin
			tape_mem[tw_addr] <= tw_data;
		end
		if (tr_en) begin
			tape_rd_q <= tape_mem[tr_addr];
		end
	end

	// Loop stack store
	always_ff @(posedge clk) begin
		if (sw_en) begin
			stk_mem[depth_q[STK_AW-1:0]] <= it.idx;
		end
		if (sr_en) begin
			stk_rd_q <= stk_mem[depth_dec[STK_AW-1:0]];
		end
	end

	// Capture draw operands as they stream in
	always_ff @(posedge clk) begin
		if (draw_cap) begin
			unique case (cnt_q)
				DRAW_CNT_W'(0): begin
					y_q    <= tape_rd_q[COORD_W-1:0];
					y_ok_q <= tape_rd_q < CELL_W'(IMAGE_SIDE);
				end
				DRAW_CNT_W'(1): begin
					r_q <= tape_rd_q[COLOR_W-1:0];
				end
				default: begin
					g_q <= tape_rd_q[COLOR_W-1:0];
				end
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			dp_q    <= '0;
			cur_q   <= '0;
			depth_q <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + TAPE_AW'(1);
			end
			if (cur_we) begin
				cur_q <= cur_nx;
			end
			if (dp_we) begin
				dp_q <= dp_nx;
			end
			if (depth_we) begin
				depth_q <= depth_nx;
			end
			if (state_q != ST_DRAW) begin
				cnt_q <= '0;
			end else if (draw_cap) begin
				cnt_q <= cnt_q + DRAW_CNT_W'(1);
			end
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (produce) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// Output word
	always_ff @(posedge clk) begin
		if (produce) begin
			o_next_q <= res_next;
			o_cv_q   <= res_cv;
			o_char_q <= res_char;
			o_pv_q   <= res_pv;
			o_row_q  <= res_row;
			o_col_q  <= res_col;
			o_r_q    <= res_r;
			o_g_q    <= res_g;
			o_b_q    <= res_b;
			o_err_q  <= res_err;
		end
	end

	assign stat.pop        = pop;
	assign stat.busy_clear = (state_q == ST_CLEAR);

	assign out_valid   = ovalid_q;
	assign next_index  = o_next_q;
	assign char_valid  = o_cv_q;
	assign char_out    = o_char_q;
	assign pixel_valid = o_pv_q;
	assign pixel_row   = o_row_q;
	assign pixel_col   = o_col_q;
	assign red         = o_r_q;
	assign green       = o_g_q;
	assign blue        = o_b_q;
	assign stack_error = o_err_q;

	`TMPD_NEVER(a_port_conflict, tw_en && tr_en, "tape read and write in one cycle")
	`TMPD_ASSERT(a_depth_bound, depth_q <= DEPTH_W'(LOOP_DEPTH), "loop depth over limit")
	`TMPD_ASSERT(a_move_from_exec, (state_q == ST_MOVE) |-> ($past(state_q) == ST_EXEC),
		"cell reload without a pointer move")
	`TMPD_NEVER(a_clear_no_pop, (state_q == ST_CLEAR) && pop, "command retired while clearing")

endmodule

`default_nettype wire
